### rtl/core/lbfs_pkg.sv
// ----------------------------------------------------------------------------
// lbfs_pkg: shared constants for the linked-block file store
// Sizes, end mark, action and status codes.
// ----------------------------------------------------------------------------
package lbfs_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int NUM_BLOCKS  = 255;
  localparam int BLOCK_BYTES = 256;
  localparam int DATA_BYTES  = BLOCK_BYTES - 4;
  localparam int NAME_BYTES  = 8;
  localparam int STORE_DEPTH = NUM_BLOCKS * DATA_BYTES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [7:0] END_MARK = 8'hFF;

  localparam logic [2:0] ACT_FORMAT = 3'd0;
  localparam logic [2:0] ACT_CREATE = 3'd1;
  localparam logic [2:0] ACT_SIZE   = 3'd2;
  localparam logic [2:0] ACT_WSTART = 3'd3;
  localparam logic [2:0] ACT_WBYTE  = 3'd4;
  localparam logic [2:0] ACT_RSTART = 3'd5;
  localparam logic [2:0] ACT_RBYTE  = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERR   = 2'd1;
  localparam logic [1:0] ST_ENDED = 2'd2;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

endpackage

### rtl/core/lbfs_ram.sv
// ----------------------------------------------------------------------------
// lbfs_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/linked_block_file_store.sv
// ----------------------------------------------------------------------------
// linked_block_file_store: file table over linked data blocks
// A name lookup compares the table entries one at a time, and a block
//   allocation scans the in-use bits one per cycle.
// One beat at a time; the lookup index and the free-block scan are separate.
// Reset: synchronous; empties the table, frees all blocks, closes transfers.
// ----------------------------------------------------------------------------
module linked_block_file_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[2:0], file_name[66:3], byte_count[82:67], data_byte[90:83], pad
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], read_data[9:2], file_size[25:10], pad
  output logic [31:0] m_tdata,
  output logic        m_tlast
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_LWAIT = 4'd2;
  localparam logic [3:0] S_FREE  = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_RDAT  = 4'd5;
  localparam logic [3:0] S_RNXT  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  localparam int NUM_BLK = lbfs_pkg::NUM_BLOCKS;

  logic [3:0]  state;
  logic [2:0]  act;
  logic [63:0] nm;
  logic [15:0] cnt;
  logic [7:0]  dbyte;
  logic [4:0]  entry_total;
  logic [NUM_BLK-1:0] in_use;
  logic [1:0]  mode;
  logic [3:0]  open_entry;
  logic [7:0]  cur_blk;
  logic [7:0]  offset;
  logic [15:0] left;
  logic [4:0]  idx;
  logic [7:0]  scan;
  logic        found;
  logic [3:0]  hit;
  logic        free_ok;
  logic [7:0]  free_blk;
  logic [1:0]  o_status;
  logic [7:0]  o_rdata;
  logic [15:0] o_fsize;

  // small per-entry tables live in flops (written at one index)
  logic [63:0] e_name  [lbfs_pkg::MAX_ENTRIES];
  logic [15:0] e_size  [lbfs_pkg::MAX_ENTRIES];
  logic [7:0]  e_bcnt  [lbfs_pkg::MAX_ENTRIES];
  logic [7:0]  e_first [lbfs_pkg::MAX_ENTRIES];

  // link RAM and byte store
  logic        nx_we;
  logic [7:0]  nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic        by_we;
  logic [lbfs_pkg::STORE_AW-1:0] by_addr;
  logic [7:0]  by_rdata;

  lbfs_ram #(.WIDTH(8), .DEPTH(256)) u_next (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata));

  lbfs_ram #(.WIDTH(8), .DEPTH(lbfs_pkg::STORE_DEPTH)) u_bytes (
    .clk, .we(by_we), .waddr(by_addr), .wdata(dbyte),
    .raddr(by_addr), .rdata(by_rdata));

  assign by_addr = lbfs_pkg::STORE_AW'(cur_blk * 16'(lbfs_pkg::DATA_BYTES))
                 + lbfs_pkg::STORE_AW'(offset);
  assign nx_raddr = cur_blk;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {6'd0, o_fsize, o_rdata, o_status};

  logic [3:0] idx4;
  assign idx4 = idx[3:0];
  logic [3:0] tot4;
  assign tot4 = entry_total[3:0];

  // byte-store write strobe, only inside an open write
  always_comb begin
    by_we = (state == S_EXEC) && (act == lbfs_pkg::ACT_WBYTE) &&
            (mode == lbfs_pkg::MODE_WRITE);
  end

  // single sequencer: lookup compare, free scan, execute, read data, next-block scan, link write, output
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_total <= '0;
      in_use <= '0;
      mode <= lbfs_pkg::MODE_IDLE;
      open_entry <= '0;
      cur_blk <= '0;
      offset <= '0;
      left <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act <= s_tdata[2:0];
            nm <= s_tdata[66:3];
            cnt <= s_tdata[82:67];
            dbyte <= s_tdata[90:83];
            idx <= '0;
            found <= 1'b0;
            hit <= '0;
            scan <= '0;
            free_ok <= 1'b0;
            o_status <= lbfs_pkg::ST_OK;
            o_rdata <= '0;
            o_fsize <= '0;
            m_tlast <= 1'b0;
            state <= S_EXEC;
            if (s_tdata[2:0] == lbfs_pkg::ACT_CREATE ||
                s_tdata[2:0] == lbfs_pkg::ACT_SIZE ||
                s_tdata[2:0] == lbfs_pkg::ACT_WSTART ||
                s_tdata[2:0] == lbfs_pkg::ACT_RSTART) begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (found || idx >= entry_total) begin
            state <= (act == lbfs_pkg::ACT_CREATE) ? S_FREE : S_EXEC;
          end else begin
            if (e_name[idx4] == nm) begin
              found <= 1'b1;
              hit <= idx4;
            end
            idx <= idx + 5'd1;
          end
        end
        S_FREE: begin
          // one in-use bit per cycle
          if (!in_use[scan]) begin
            free_ok <= 1'b1;
            free_blk <= scan;
            state <= S_EXEC;
          end else if (scan == 8'(NUM_BLK - 1)) begin
            state <= S_EXEC;
          end else begin
            scan <= scan + 8'd1;
          end
        end
        S_EXEC: begin
          state <= S_OUT;
          case (act)
            lbfs_pkg::ACT_FORMAT: begin
              entry_total <= '0;
              in_use <= '0;
              mode <= lbfs_pkg::MODE_IDLE;
            end
            lbfs_pkg::ACT_CREATE: begin
              if (!free_ok || entry_total >= 5'(lbfs_pkg::MAX_ENTRIES) || found) begin
                o_status <= lbfs_pkg::ST_ERR;
              end else begin
                e_name[tot4] <= nm;
                e_size[tot4] <= '0;
                e_bcnt[tot4] <= 8'd1;
                e_first[tot4] <= free_blk;
                in_use[free_blk] <= 1'b1;
                entry_total <= entry_total + 5'd1;
                state <= S_LWAIT;
              end
            end
            lbfs_pkg::ACT_SIZE: begin
              if (!found) o_status <= lbfs_pkg::ST_ERR;
              else o_fsize <= e_size[hit];
            end
            lbfs_pkg::ACT_WSTART, lbfs_pkg::ACT_RSTART: begin
              if (!found) begin
                o_status <= lbfs_pkg::ST_ERR;
                mode <= lbfs_pkg::MODE_IDLE;
              end else begin
                open_entry <= hit;
                cur_blk <= e_first[hit];
                offset <= '0;
                left <= cnt;
                if (act == lbfs_pkg::ACT_WSTART) begin
                  e_size[hit] <= cnt;
                  e_bcnt[hit] <= (cnt != 0) ? 8'd1 : 8'd0;
                  state <= S_LWAIT;
                end
                if (cnt == 0) begin
                  mode <= lbfs_pkg::MODE_IDLE;
                  m_tlast <= 1'b1;
                end else begin
                  mode <= (act == lbfs_pkg::ACT_WSTART) ?
                          lbfs_pkg::MODE_WRITE : lbfs_pkg::MODE_READ;
                end
              end
            end
            lbfs_pkg::ACT_WBYTE: begin
              // byte written this cycle by by_we; pointer update below
              if (mode != lbfs_pkg::MODE_WRITE) begin
                o_status <= lbfs_pkg::ST_ERR;
              end else begin
                offset <= offset + 8'd1;
                left <= left - 16'd1;
                if (left == 16'd1) begin
                  mode <= lbfs_pkg::MODE_IDLE;
                  m_tlast <= 1'b1;
                end else if (offset == 8'(lbfs_pkg::DATA_BYTES - 1)) begin
                  scan <= '0;
                  state <= S_RNXT;
                end
              end
            end
            lbfs_pkg::ACT_RBYTE: begin
              if (mode != lbfs_pkg::MODE_READ) begin
                o_status <= lbfs_pkg::ST_ERR;
              end else if (cur_blk >= 8'(NUM_BLK)) begin
                o_status <= lbfs_pkg::ST_ENDED;
                m_tlast <= 1'b1;
                mode <= lbfs_pkg::MODE_IDLE;
              end else begin
                state <= S_RDAT;
              end
            end
            default: o_status <= lbfs_pkg::ST_ERR;
          endcase
        end
        S_RDAT: begin
          // registered byte and link reads are valid now
          o_rdata <= by_rdata;
          left <= left - 16'd1;
          state <= S_OUT;
          if (left == 16'd1) begin
            mode <= lbfs_pkg::MODE_IDLE;
            m_tlast <= 1'b1;
            offset <= offset + 8'd1;
          end else if (offset == 8'(lbfs_pkg::DATA_BYTES - 1)) begin
            cur_blk <= nx_rdata;
            offset <= '0;
          end else begin
            offset <= offset + 8'd1;
          end
        end
        S_RNXT: begin
          // block filled mid-write: scan for the next free block
          if (!in_use[scan]) begin
            in_use[scan] <= 1'b1;
            free_blk <= scan;
            free_ok <= 1'b1;
            offset <= '0;
            if (e_bcnt[open_entry] != 8'hFF)
              e_bcnt[open_entry] <= e_bcnt[open_entry] + 8'd1;
            state <= S_LWAIT;
          end else if (scan == 8'(NUM_BLK - 1)) begin
            mode <= lbfs_pkg::MODE_IDLE;
            o_status <= lbfs_pkg::ST_ERR;
            free_ok <= 1'b0;
            state <= S_LWAIT;
          end else begin
            scan <= scan + 8'd1;
          end
        end
        S_LWAIT: begin
          // link write happens in the combinational block below; finish
          if (act == lbfs_pkg::ACT_WBYTE && free_ok) cur_blk <= free_blk;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // link RAM writes from S_LWAIT: chain end marks and new links
  logic        lk_we, lk_we2;
  always_comb begin
    lk_we = (state == S_LWAIT);
    lk_we2 = lk_we && act == lbfs_pkg::ACT_WBYTE && free_ok;
  end

  // second phase writes end mark on the new block
  logic       pend;
  logic [7:0] pend_addr;
  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else begin
      pend <= lk_we2;
      pend_addr <= free_blk;
    end
  end

  // link RAM port: end marks on created, restarted or unextendable chains, or a new link
  always_comb begin
    nx_we = lk_we || pend;
    nx_waddr = cur_blk;
    nx_wdata = lbfs_pkg::END_MARK;
    if (pend) begin
      nx_waddr = pend_addr;
    end else if (act == lbfs_pkg::ACT_CREATE) begin
      nx_waddr = free_blk;
    end else if (lk_we2) begin
      nx_wdata = free_blk;
    end
  end

  // assertions
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("ready while busy");
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3)) else $error("bad status code");
  a_ended: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == lbfs_pkg::ST_ENDED) |-> m_tlast)
    else $error("chain end without last");

endmodule
